>>> hw/rtl/lfte_pkg.sv
// shared types, constants and codes of the led fade table engine
`default_nettype none
package lfte_pkg;

  // widths of levels and times
  localparam int LEVEL_W = 8;
  localparam int TIME_W  = 32;
  localparam int PROD_W  = LEVEL_W + TIME_W;

  // default table size
  localparam int LED_COUNT_DEF = 256;

  // full brightness level
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;

  // item kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // start effects
  localparam logic [1:0] EFF_NONE   = 2'd0;
  localparam logic [1:0] EFF_IN     = 2'd1;
  localparam logic [1:0] EFF_OUT    = 2'd2;
  localparam logic [1:0] EFF_IN_OUT = 2'd3;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_IN_OUT_MODE = 2'd0;

  // input word
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         led;
    logic [LEVEL_W-1:0] target_level;
    logic [TIME_W-1:0]  fade_ms;
    logic [1:0]         effect;
    logic [TIME_W-1:0]  now_ms;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [LEVEL_W-1:0] brightness;
    logic               any_active;
  } out_word_t;

  // one fade table entry as kept in the table ram
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] start_lvl;
    logic [LEVEL_W-1:0] end_lvl;
    logic [TIME_W-1:0]  length;
    logic [TIME_W-1:0]  origin;
  } entry_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/led_fade_table_engine_top.sv
// led fade table engine: sequencer around the fade table ram and the divider
//
//  channel  direction  handshake          word
//  in_      input      in_valid/in_stall  lfte_pkg::in_word_t
//  out_     output     out_valid/out_stall lfte_pkg::out_word_t
//  apb      input      psel/penable/pready in_out_mode at byte address 0
//
// a start writes one entry, a clear writes every entry, an update walks every entry (one ram read per entry)
// a query reads its entry, then an 8x32 multiply and the 8-step divider give the level
// after reset every table entry is cleared before the first word is taken
// one word is worked at a time; in_stall is high until its result sits in the output register
// a result held by out_stall waits in the output register, the next word is taken meanwhile
`default_nettype none
module led_fade_table_engine_top #(
  parameter int LED_COUNT = lfte_pkg::LED_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire lfte_pkg::in_word_t                  in_word,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output lfte_pkg::out_word_t                      out_word,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lfte_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lfte_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [lfte_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CNT_W = $clog2(LED_COUNT + 1);
  localparam int ENT_W = $bits(lfte_pkg::entry_t);
  localparam int LW    = lfte_pkg::LEVEL_W;
  localparam int TW    = lfte_pkg::TIME_W;
  localparam int PW    = lfte_pkg::PROD_W;

  // sequencer states
  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_UPD   = 4'd3;
  localparam logic [3:0] ST_CLR   = 4'd4;
  localparam logic [3:0] ST_QEV   = 4'd5;
  localparam logic [3:0] ST_QMUL  = 4'd6;
  localparam logic [3:0] ST_QDS   = 4'd7;
  localparam logic [3:0] ST_QDIV  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ev_pend_r, ev_pend_nxt;
  logic [IDX_W-1:0]       ev_idx_r, ev_idx_nxt;
  logic                   run_r, run_nxt;
  logic                   out_valid_r, out_valid_nxt;
  lfte_pkg::out_word_t    out_word_r, out_word_nxt;
  logic                   mode_r, mode_nxt;
  lfte_pkg::in_word_t     item_r, item_nxt;
  logic                   in_range_r, in_range_nxt;
  lfte_pkg::out_word_t    res_r, res_nxt;
  logic [LW-1:0]          s_r, s_nxt;
  logic                   up_r, up_nxt;
  logic [LW-1:0]          diff_r, diff_nxt;
  logic [TW-1:0]          elapsed_r, elapsed_nxt;
  logic [TW-1:0]          len_r, len_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  lfte_pkg::entry_t       ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  lfte_pkg::entry_t       ram_rdata;
  logic [ENT_W-1:0]       ram_rbits;

  logic                   div_start;
  lfte_pkg::div_sts_t     div_sts;
  logic [LW-1:0]          div_quot;

  logic [TW-1:0]          elapsed_c;
  logic                   cfg_wr;

  // fade table
  lfte_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LED_COUNT),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = lfte_pkg::entry_t'(ram_rbits);

  // interpolation divider
  lfte_div #(
    .DEN_W (TW),
    .Q_W   (LW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (len_r),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  // configuration register
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == lfte_pkg::REG_IN_OUT_MODE) ?
                  {{(lfte_pkg::CFG_DATA_W-1){1'b0}}, mode_r} : '0;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && paddr == lfte_pkg::REG_IN_OUT_MODE) begin
      mode_nxt = pwdata[0];
    end
  end

  // elapsed time of the entry just read, wrapping
  assign elapsed_c = item_r.now_ms - ram_rdata.origin;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ev_pend_nxt   = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    run_nxt       = run_r;
    item_nxt      = item_r;
    in_range_nxt  = in_range_r;
    res_nxt       = res_r;
    s_nxt         = s_r;
    up_nxt        = up_r;
    diff_nxt      = diff_r;
    elapsed_nxt   = elapsed_r;
    len_nxt       = len_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = ev_idx_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = IDX_W'(in_word.led);
    div_start     = 1'b0;

    unique case (state_r)
      // table sweep after reset and for a clear word
      ST_INIT, ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IDX_W-1:0];
        ram_wdata = '0;
        if (cnt_r == CNT_W'(LED_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      // take a word; the ram read of its led is issued on the same edge
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_word;
          in_range_nxt = ({24'b0, in_word.led} < 32'(LED_COUNT));
          res_nxt      = '0;
          cnt_nxt      = '0;
          run_nxt      = 1'b0;
          unique case (in_word.kind)
            lfte_pkg::KIND_START:  state_nxt = ST_START;
            lfte_pkg::KIND_UPDATE: state_nxt = ST_UPD;
            lfte_pkg::KIND_QUERY:  state_nxt = ST_QEV;
            lfte_pkg::KIND_CLEAR:  state_nxt = ST_CLR;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end

      // write the new entry
      ST_START: begin
        ram_waddr        = IDX_W'(item_r.led);
        ram_we           = in_range_r;
        ram_wdata.valid  = 1'b1;
        ram_wdata.length = item_r.fade_ms;
        ram_wdata.origin = item_r.now_ms;
        unique case (item_r.effect)
          lfte_pkg::EFF_IN: begin
            ram_wdata.start_lvl = '0;
            ram_wdata.end_lvl   = item_r.target_level;
          end
          lfte_pkg::EFF_OUT: begin
            ram_wdata.start_lvl = lfte_pkg::FULL_LEVEL;
            ram_wdata.end_lvl   = '0;
          end
          lfte_pkg::EFF_IN_OUT: begin
            ram_wdata.start_lvl = '0;
            ram_wdata.end_lvl   = lfte_pkg::FULL_LEVEL;
          end
          default: begin
            ram_wdata.start_lvl = item_r.target_level;
            ram_wdata.end_lvl   = item_r.target_level;
            ram_wdata.length    = '0;
          end
        endcase
        state_nxt = ST_FIN;
      end

      // walk: read entry n while entry n-1 is checked and written back
      ST_UPD: begin
        if (cnt_r != CNT_W'(LED_COUNT)) begin
          ram_raddr   = cnt_r[IDX_W-1:0];
          ev_idx_nxt  = cnt_r[IDX_W-1:0];
          ev_pend_nxt = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
        if (ev_pend_r && ram_rdata.valid) begin
          if (elapsed_c < ram_rdata.length) begin
            run_nxt = 1'b1;
          end else begin
            ram_we = 1'b1;
            if (mode_r && ram_rdata.end_lvl == lfte_pkg::FULL_LEVEL) begin
              ram_wdata.start_lvl = lfte_pkg::FULL_LEVEL;
              ram_wdata.end_lvl   = '0;
              ram_wdata.origin    = item_r.now_ms;
            end else begin
              ram_wdata.valid = 1'b0;
            end
          end
        end
        if (cnt_r == CNT_W'(LED_COUNT) && !ev_pend_r) begin
          res_nxt.any_active = run_r;
          state_nxt          = ST_FIN;
        end
      end

      // query: classify the entry
      ST_QEV: begin
        if (!in_range_r || !ram_rdata.valid) begin
          res_nxt.brightness = lfte_pkg::FULL_LEVEL;
          state_nxt          = ST_FIN;
        end else if (elapsed_c >= ram_rdata.length) begin
          res_nxt.brightness = ram_rdata.end_lvl;
          state_nxt          = ST_FIN;
        end else begin
          s_nxt       = ram_rdata.start_lvl;
          up_nxt      = (ram_rdata.end_lvl >= ram_rdata.start_lvl);
          diff_nxt    = (ram_rdata.end_lvl >= ram_rdata.start_lvl) ?
                        (ram_rdata.end_lvl - ram_rdata.start_lvl) :
                        (ram_rdata.start_lvl - ram_rdata.end_lvl);
          elapsed_nxt = elapsed_c;
          len_nxt     = ram_rdata.length;
          state_nxt   = ST_QMUL;
        end
      end

      // level span times elapsed time
      ST_QMUL: begin
        prod_nxt  = PW'(diff_r) * PW'(elapsed_r);
        state_nxt = ST_QDS;
      end

      ST_QDS: begin
        div_start = 1'b1;
        state_nxt = ST_QDIV;
      end

      // wait for the quotient and apply it in the fade direction
      ST_QDIV: begin
        if (div_sts.done) begin
          res_nxt.brightness = up_r ? (s_r + div_quot) : (s_r - div_quot);
          state_nxt          = ST_FIN;
        end
      end

      // hand the result to the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      ev_pend_r   <= 1'b0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ev_pend_r   <= ev_pend_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ev_idx_r   <= ev_idx_nxt;
    item_r     <= item_nxt;
    in_range_r <= in_range_nxt;
    res_r      <= res_nxt;
    s_r        <= s_nxt;
    up_r       <= up_nxt;
    diff_r     <= diff_nxt;
    elapsed_r  <= elapsed_nxt;
    len_r      <= len_nxt;
    prod_r     <= prod_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  // divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_QDIV)
    else $error("divider done outside query wait");

  // a query never writes the table
  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QEV || state_r == ST_QMUL || state_r == ST_QDS ||
     state_r == ST_QDIV) |-> !ram_we)
    else $error("table write during query");

  // a pending check belongs to an update walk
  a_walk_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ev_pend_r |-> state_r == ST_UPD)
    else $error("entry check outside update walk");

  // only a query reports a brightness
  a_brightness_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && item_r.kind != lfte_pkg::KIND_QUERY) |->
    res_r.brightness == '0)
    else $error("brightness on a non-query word");

  // a result leaves the sequencer only into a free output register
  a_fin_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && state_nxt == ST_IDLE) |=>
    (out_valid_r && out_word_r == $past(res_r)))
    else $error("result not loaded into output register");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/lfte_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module lfte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/lfte_div.sv
// iterative restoring divider, one quotient bit per cycle, short quotient
`default_nettype none
module lfte_div #(
  parameter int DEN_W = lfte_pkg::TIME_W,
  parameter int Q_W   = lfte_pkg::LEVEL_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [DEN_W+Q_W-1:0]   num,
  input  wire logic [DEN_W-1:0]       den,
  output lfte_pkg::div_sts_t          sts,
  output logic      [Q_W-1:0]         quot
);

  localparam int CW = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [Q_W-1:0]   low_r, low_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             ge;

  // one shift-compare-subtract step
  always_comb begin
    trial    = {rem_r, low_r[Q_W-1]};
    ge       = (trial >= {1'b0, den_r});
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      // quotient fits Q_W bits, so the top bits are already below den
      rem_nxt = num[DEN_W+Q_W-1:Q_W];
      low_nxt = num[Q_W-1:0];
      den_nxt = den;
      cnt_nxt = CW'(Q_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      low_nxt  = {low_r[Q_W-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quot     = low_r;

endmodule
`default_nettype wire

>>> test/led_fade_checker.sv
// fade table checker: predicts each result word of the engine and compares it
module led_fade_checker
  import lfte_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_word_t  in_word,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_word_t out_word,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic      pready,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output int             errors,
  output int             pending
);

  localparam int LEDS = LED_COUNT_DEF;

  // shadow fade table
  logic               live     [LEDS];
  logic [LEVEL_W-1:0] from_lvl [LEDS];
  logic [LEVEL_W-1:0] to_lvl   [LEDS];
  logic [TIME_W-1:0]  span     [LEDS];
  logic [TIME_W-1:0]  origin   [LEDS];
  logic               inout_mode;

  // result words still owed by the engine, oldest first
  out_word_t due_results[$];

  // current level of one led, integer interpolation while the fade runs
  function automatic logic [LEVEL_W-1:0] level_now(logic [7:0] led, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0]  elapsed;
    logic [LEVEL_W-1:0] diff;
    logic [63:0]        q;
    if (!live[led]) return FULL_LEVEL;
    elapsed = now - origin[led];
    if (elapsed >= span[led]) return to_lvl[led];
    diff = (to_lvl[led] >= from_lvl[led]) ? to_lvl[led] - from_lvl[led]
                                          : from_lvl[led] - to_lvl[led];
    q = ({56'd0, diff} * {32'd0, elapsed}) / {32'd0, span[led]};
    if (to_lvl[led] >= from_lvl[led]) return from_lvl[led] + q[LEVEL_W-1:0];
    return from_lvl[led] - q[LEVEL_W-1:0];
  endfunction

  // walk the table: retire finished fades, turn finished fade-ins around
  function automatic logic tick_table(logic [TIME_W-1:0] now);
    logic running;
    running = 1'b0;
    for (int i = 0; i < LEDS; i++) begin
      if (live[i]) begin
        if (now - origin[i] < span[i]) begin
          running = 1'b1;
        end else if (inout_mode && to_lvl[i] == FULL_LEVEL) begin
          from_lvl[i] = FULL_LEVEL;
          to_lvl[i]   = '0;
          origin[i]   = now;
        end else begin
          live[i] = 1'b0;
        end
      end
    end
    return running;
  endfunction

  // load one entry from a start word
  function automatic void load_fade(in_word_t w);
    live[w.led]   = 1'b1;
    span[w.led]   = w.fade_ms;
    origin[w.led] = w.now_ms;
    case (w.effect)
      EFF_IN: begin
        from_lvl[w.led] = '0;
        to_lvl[w.led]   = w.target_level;
      end
      EFF_OUT: begin
        from_lvl[w.led] = FULL_LEVEL;
        to_lvl[w.led]   = '0;
      end
      EFF_IN_OUT: begin
        from_lvl[w.led] = '0;
        to_lvl[w.led]   = FULL_LEVEL;
      end
      default: begin
        from_lvl[w.led] = w.target_level;
        to_lvl[w.led]   = w.target_level;
        span[w.led]     = '0;
      end
    endcase
  endfunction

  // expected result of one accepted input word, table updated on the way
  function automatic out_word_t result_of(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.kind)
      KIND_START:  load_fade(w);
      KIND_UPDATE: r.any_active = tick_table(w.now_ms);
      KIND_QUERY:  r.brightness = level_now(w.led, w.now_ms);
      default: begin
        for (int i = 0; i < LEDS; i++) live[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      inout_mode = 1'b0;
      for (int i = 0; i < LEDS; i++) begin
        live[i]     = 1'b0;
        from_lvl[i] = '0;
        to_lvl[i]   = '0;
        span[i]     = '0;
        origin[i]   = '0;
      end
      due_results.delete();
    end else begin
      // register write on the access phase
      if (psel && penable && pwrite && pready && paddr == REG_IN_OUT_MODE)
        inout_mode = pwdata[0];
      // result side first: a word taken at this edge cannot answer itself
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result word: brightness %0d any_active %0d",
                   $time, out_word.brightness, out_word.any_active);
        end else begin
          want = due_results.pop_front();
          if (out_word.brightness !== want.brightness) begin
            errors++;
            $display("%0t brightness mismatch: expected %0d, actual %0d",
                     $time, want.brightness, out_word.brightness);
          end
          if (out_word.any_active !== want.any_active) begin
            errors++;
            $display("%0t any_active mismatch: expected %0d, actual %0d",
                     $time, want.any_active, out_word.any_active);
          end
        end
      end
      // queue the prediction behind the older ones
      if (in_valid && !in_stall)
        due_results.insert(due_results.size(), result_of(in_word));
    end
    pending <= due_results.size();
  end

endmodule

>>> test/led_fade_table_engine_top_tb.sv
// testbench top: stimulus, flow control and verdict for the led fade table engine
module led_fade_table_engine_top_tb;
  import lfte_pkg::*;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 213;
  localparam int HOLD_CYCLES   = 700;
  localparam logic [RANDOM_PHASES-1:0] MODE_PLAN = 6'b010110;

  // receiver stall patterns
  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_EVERY4 = 3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    pending;

  // sender state
  int                 burst_left = 0;
  logic [TIME_W-1:0]  t_now      = '0;
  logic [7:0]         pool [8];

  always #10 clk = ~clk;

  led_fade_table_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  led_fade_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (errors),
    .pending   (pending)
  );

  // one input word from its fields
  function automatic in_word_t fade_word(logic [1:0] kind, logic [7:0] led, logic [7:0] target,
                                         logic [31:0] fade, logic [1:0] eff, logic [31:0] now);
    in_word_t w;
    w.kind         = kind;
    w.led          = led;
    w.target_level = target;
    w.fade_ms      = fade;
    w.effect       = eff;
    w.now_ms       = now;
    return w;
  endfunction

  // random word: mostly a coherent timeline on a few leds, some raw noise
  function automatic in_word_t next_word();
    in_word_t w;
    int       r;
    if ($urandom_range(0, 99) < 5) begin
      w.kind         = 2'($urandom_range(0, 3));
      w.led          = 8'($urandom_range(0, 255));
      w.target_level = 8'($urandom_range(0, 255));
      w.fade_ms      = $urandom;
      w.effect       = 2'($urandom_range(0, 3));
      w.now_ms       = $urandom;
      return w;
    end
    r = $urandom_range(0, 99);
    w.kind = (r < 30) ? KIND_START : (r < 52) ? KIND_UPDATE : (r < 96) ? KIND_QUERY : KIND_CLEAR;
    t_now += (w.kind == KIND_UPDATE) ? $urandom_range(0, 300) : $urandom_range(0, 30);
    w.led = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 7)]
                                         : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    w.target_level = (r < 20) ? FULL_LEVEL : (r < 30) ? 8'd0 : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    w.fade_ms = (r < 10) ? 32'd0 : (r < 85) ? $urandom_range(1, 400) :
                (r < 95) ? $urandom_range(401, 5000) : $urandom;
    w.effect = 2'($urandom_range(0, 3));
    w.now_ms = t_now;
    return w;
  endfunction

  // offer one word, in bursts with random gaps, until taken
  task automatic offer(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every result has come back
  task automatic settle(input int extra);
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  // apb write of the in-out mode register: setup, then access
  task automatic write_mode(input logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_IN_OUT_MODE;
    pwdata  <= {{(CFG_DATA_W-1){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // receiver: changing stall patterns, plus long hold-offs that back up the engine
  initial begin
    int cyc, hold_left, pat, pat_left;
    cyc       = 0;
    hold_left = 0;
    pat       = STALL_NONE;
    pat_left  = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 9000 || cyc == 60000) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat      = $urandom_range(STALL_NONE, STALL_EVERY4);
          pat_left = $urandom_range(40, 400);
        end
        pat_left--;
        case (pat)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  // main stimulus and verdict
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);

    // directed: idle led, each effect, zero length, wrapping time, clear
    offer(fade_word(KIND_QUERY,  8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd0));
    offer(fade_word(KIND_START,  8'd0,   8'd77,  32'd500,      EFF_NONE,   32'd100));
    offer(fade_word(KIND_QUERY,  8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd100));
    offer(fade_word(KIND_START,  8'd255, 8'd255, 32'hFFFFFFFF, EFF_IN,     32'hFFFFFFF0));
    offer(fade_word(KIND_QUERY,  8'd255, 8'd0,   32'd0,        EFF_NONE,   32'h7FFFFFFF));
    offer(fade_word(KIND_START,  8'd1,   8'd0,   32'd1000,     EFF_OUT,    32'd0));
    offer(fade_word(KIND_QUERY,  8'd1,   8'd0,   32'd0,        EFF_NONE,   32'd500));
    offer(fade_word(KIND_START,  8'd2,   8'd0,   32'd10,       EFF_IN_OUT, 32'hFFFFFFFA));
    offer(fade_word(KIND_QUERY,  8'd2,   8'd0,   32'd0,        EFF_NONE,   32'd3));
    offer(fade_word(KIND_START,  8'd5,   8'd200, 32'd0,        EFF_IN,     32'd10));
    offer(fade_word(KIND_QUERY,  8'd5,   8'd0,   32'd0,        EFF_NONE,   32'd10));
    offer(fade_word(KIND_UPDATE, 8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd5));
    offer(fade_word(KIND_QUERY,  8'd1,   8'd0,   32'd0,        EFF_NONE,   32'd999));
    offer(fade_word(KIND_UPDATE, 8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd2000));
    offer(fade_word(KIND_START,  8'd128, 8'd0,   32'd100,      EFF_IN,     32'd50));
    offer(fade_word(KIND_QUERY,  8'd128, 8'd0,   32'd0,        EFF_NONE,   32'd60));
    offer(fade_word(KIND_CLEAR,  8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd0));
    offer(fade_word(KIND_UPDATE, 8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd0));
    offer(fade_word(KIND_QUERY,  8'd255, 8'd0,   32'd0,        EFF_NONE,   32'd0));
    settle(20);

    // directed, in-out mode: fades to full turn around on update
    write_mode(1'b1);
    offer(fade_word(KIND_START,  8'd3,   8'd0,   32'd100,      EFF_IN_OUT, 32'd1000));
    offer(fade_word(KIND_START,  8'd4,   8'd255, 32'd50,       EFF_IN,     32'd1000));
    offer(fade_word(KIND_UPDATE, 8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd1100));
    offer(fade_word(KIND_QUERY,  8'd3,   8'd0,   32'd0,        EFF_NONE,   32'd1150));
    offer(fade_word(KIND_UPDATE, 8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd1150));
    offer(fade_word(KIND_UPDATE, 8'd0,   8'd0,   32'd0,        EFF_NONE,   32'd1300));
    offer(fade_word(KIND_QUERY,  8'd3,   8'd0,   32'd0,        EFF_NONE,   32'd1300));
    settle(20);

    // random phases, the mode register set per phase from MODE_PLAN
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_mode(MODE_PLAN[p]);
      pool[0] = 8'd0;
      pool[1] = 8'd255;
      for (int i = 2; i < 8; i++) pool[i] = 8'($urandom_range(0, 255));
      // one phase runs across the 32-bit time wrap
      t_now = (p == 2) ? 32'hFFFFFC00 : $urandom;
      for (int i = 0; i < PHASE_WORDS; i++) offer(next_word());
      settle(20);
    end

    settle(300);
    if (errors == 0 && pending == 0) begin
      $display("led_fade_table_engine_top_tb: PASS");
    end else begin
      $display("led_fade_table_engine_top_tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("led_fade_table_engine_top_tb: FAIL");
    $finish;
  end

endmodule

>>> led_fade_table_engine_top.f
hw/rtl/lfte_pkg.sv
hw/rtl/lfte_ram.sv
hw/rtl/lfte_div.sv
hw/rtl/led_fade_table_engine_top.sv
test/led_fade_checker.sv
test/led_fade_table_engine_top_tb.sv
